// ===== hw/rtl/bmpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpu_pkg: shared types and constants for the bicycle model pose update
// Holds the sequencer states, item kinds, register indexes, unit widths and
// the CORDIC arctangent table, plus the rounding and saturation helpers.
// ----------------------------------------------------------------------------
package bmpu_pkg;

  // Item kinds
  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic REG_TIME_STEP      = 1'b0;
  localparam logic REG_INV_WHEEL_BASE = 1'b1;

  localparam logic [15:0] TIME_STEP_RST      = 16'd3277;
  localparam logic [15:0] INV_WHEEL_BASE_RST = 16'd23884;

  // Steering limit, 70 degrees in binary angle units
  localparam int unsigned STEER_LIMIT = 12743;

  // Tan table size and the table index arithmetic
  localparam int unsigned TAN_TABLE_DEPTH = 512;
  // Divide by STEER_LIMIT as a reciprocal multiply; exact for numerators below 2^23
  localparam int unsigned TAN_IDX_RECIP = 10785448;
  localparam int unsigned TAN_IDX_SHIFT = 37;
  // 32-bit binary angle of one table entry
  localparam int unsigned TAN_ANG_STEP  = STEER_LIMIT * 65536 / TAN_TABLE_DEPTH;

  // 65536/(2pi) in Q16
  localparam logic signed [33:0] RAD_TO_BAM = 34'sd683565276;

  // 0.6072529 in Q30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Shared datapath widths
  localparam int unsigned DAT_W     = 34;
  localparam int unsigned PROD_W    = 2 * DAT_W;
  localparam int unsigned DIV_NUM_W = 50;
  localparam int unsigned DIV_DEN_W = 34;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned TN_W      = 20;
  localparam int unsigned ATAN_N    = 24;

  localparam logic [30:0] ATAN_ROM [ATAN_N] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
    31'd21354465, 31'd10680862, 31'd5340245, 31'd2670163, 31'd1335087,
    31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
    31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163, 31'd81
  };

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IDX_GO,
    ST_IDX_WAIT,
    ST_ANG_GO,
    ST_ANG_WAIT,
    ST_TANC_GO,
    ST_TANC_WAIT,
    ST_TAND_GO,
    ST_TAND_WAIT,
    ST_P_MUL,
    ST_R_MUL,
    ST_T_MUL,
    ST_D_MUL,
    ST_HEAD_GO,
    ST_HEAD_WAIT,
    ST_X_MUL,
    ST_Y_MUL,
    ST_Y_SUM,
    ST_OUT
  } state_e;

  // Round half up, then arithmetic right shift; keep the low DAT_W bits
  function automatic logic signed [DAT_W-1:0] round_shr(
    input logic signed [PROD_W-1:0] v,
    input int unsigned              n
  );
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] shifted;
    sum     = v + (PROD_W'(1) << (n - 1));
    shifted = sum >>> n;
    return shifted[DAT_W-1:0];
  endfunction

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [DAT_W-1:0] v);
    logic signed [DAT_W-1:0] hi;
    logic signed [DAT_W-1:0] lo;
    hi = DAT_W'(32'sh7fffffff);
    lo = -(DAT_W'(33'sh080000000));
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/bmpu_mul.sv =====
// ----------------------------------------------------------------------------
// bmpu_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module bmpu_mul (
  input  logic                                 clk_i,
  input  logic signed [bmpu_pkg::DAT_W-1:0]    a_i,
  input  logic signed [bmpu_pkg::DAT_W-1:0]    b_i,
  output logic signed [bmpu_pkg::PROD_W-1:0]   prod_o
);

  logic signed [bmpu_pkg::PROD_W-1:0] prod_q;
  logic signed [bmpu_pkg::PROD_W-1:0] prod_d;

  assign prod_d = bmpu_pkg::PROD_W'(a_i) * bmpu_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/bmpu_div.sv =====
// ----------------------------------------------------------------------------
// bmpu_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmpu_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [bmpu_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [bmpu_pkg::DIV_DEN_W-1:0]     den_i,
  output logic                               done_o,
  output logic [bmpu_pkg::DIV_NUM_W-1:0]     quot_o
);

  localparam int unsigned NW = bmpu_pkg::DIV_NUM_W;
  localparam int unsigned DW = bmpu_pkg::DIV_DEN_W;

  logic                           busy_q;
  logic                           done_q;
  logic [bmpu_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [NW-1:0]                  num_q;
  logic [DW-1:0]                  den_q;
  logic [DW-1:0]                  rem_q;
  logic [DW:0]                    rem_sh;
  logic                           qbit;
  logic [DW:0]                    rem_d;

  always_comb begin
    rem_sh = {rem_q, num_q[NW-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    rem_d  = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == bmpu_pkg::DIV_CNT_W'(NW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], qbit};
      rem_q <= rem_d[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// ===== hw/rtl/bmpu_cordic.sv =====
// ----------------------------------------------------------------------------
// bmpu_cordic: iterative rotation-mode CORDIC
// One micro-rotation per cycle; gives cosine and sine in Q4.30.
// ----------------------------------------------------------------------------
module bmpu_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [31:0]                         angle_i,
  output logic                                done_o,
  output logic signed [bmpu_pkg::DAT_W-1:0]   cos_o,
  output logic signed [bmpu_pkg::DAT_W-1:0]   sin_o
);

  localparam int unsigned CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int unsigned DW    = bmpu_pkg::DAT_W;

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [DW-1:0]    x_q;
  logic signed [DW-1:0]    y_q;
  logic signed [32:0]      z_q;
  logic                    flip_q;

  logic signed [32:0]      z_in;
  logic signed [32:0]      z_pre;
  logic                    flip_pre;
  logic signed [32:0]      atan_v;
  logic signed [DW-1:0]    x_d;
  logic signed [DW-1:0]    y_d;
  logic signed [32:0]      z_d;

  // Fold the left half-plane onto the right one
  always_comb begin
    z_in     = 33'($signed(angle_i));
    z_pre    = z_in;
    flip_pre = 1'b0;
    if (z_in > 33'sd1073741824) begin
      z_pre    = z_in - 33'sd2147483648;
      flip_pre = 1'b1;
    end else if (z_in < -33'sd1073741824) begin
      z_pre    = z_in + 33'sd2147483648;
      flip_pre = 1'b1;
    end
  end

  always_comb begin
    atan_v = $signed({2'b00, bmpu_pkg::ATAN_ROM[5'(cnt_q)]});
    if (z_q >= 0) begin
      x_d = x_q - (y_q >>> cnt_q);
      y_d = y_q + (x_q >>> cnt_q);
      z_d = z_q - atan_v;
    end else begin
      x_d = x_q + (y_q >>> cnt_q);
      y_d = y_q - (x_q >>> cnt_q);
      z_d = z_q + atan_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= bmpu_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= z_pre;
      flip_q <= flip_pre;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

// ===== hw/rtl/bicycle_model_pose_update.sv =====
// ----------------------------------------------------------------------------
// bicycle_model_pose_update: kinematic bicycle model dead reckoning
// Step transactions turn the heading by the bicycle yaw increment and then
// move x/y along the new heading; load transactions set the pose.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. A load shows its result the cycle
// after accept. A step runs two passes of the iterative CORDIC (table angle,
// then the new heading) and the restoring divider that forms tan = sin/cos.
// The tan table index and the table angle come from the one shared registered
// multiplier, which also does every other product. The result is held on the
// output until it is taken; in_ready_o stays low from accept until then.
// Configuration writes take effect at once and should only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module bicycle_model_pose_update #(
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_kind_i,
  input  logic signed [15:0] in_speed_i,
  input  logic signed [14:0] in_steer_angle_i,
  input  logic signed [31:0] in_new_x_i,
  input  logic signed [31:0] in_new_y_i,
  input  logic [15:0]        in_new_heading_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic [15:0]        out_heading_o
);

  localparam int unsigned DW    = bmpu_pkg::DAT_W;
  localparam int unsigned PW    = bmpu_pkg::PROD_W;
  localparam int unsigned NW    = bmpu_pkg::DIV_NUM_W;
  localparam int unsigned DNW   = bmpu_pkg::DIV_DEN_W;
  localparam int unsigned TW    = bmpu_pkg::TN_W;
  localparam int unsigned IDX_W = $clog2(bmpu_pkg::TAN_TABLE_DEPTH + 1);

  localparam logic signed [14:0] STEER_POS = 15'(bmpu_pkg::STEER_LIMIT);

  // Sequencer
  bmpu_pkg::state_e state_q;
  bmpu_pkg::state_e state_d;

  // Configuration
  logic [15:0] ts_q;
  logic [15:0] iwb_q;

  // Pose
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic [15:0]        heading_q;

  // Per-step working registers
  logic signed [15:0] speed_q;
  logic               steer_neg_q;
  logic [13:0]        mag_q;
  logic [IDX_W-1:0]   idx_q;
  logic [31:0]        ang_q;
  logic signed [31:0] p_q;
  logic signed [TW-1:0] tn_q;

  // Shared units
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic                 div_start;
  logic [NW-1:0]        div_num;
  logic [DNW-1:0]       div_den;
  logic                 div_done;
  logic [NW-1:0]        div_quot;
  logic                 cor_start;
  logic [31:0]          cor_angle;
  logic                 cor_done;
  logic signed [DW-1:0] cor_cos;
  logic signed [DW-1:0] cor_sin;

  // Datapath helpers
  logic signed [14:0]   steer_clamped;
  logic [13:0]          steer_mag;
  logic signed [DW-1:0] rnd16;
  logic signed [DW-1:0] rnd38;
  logic signed [DW-1:0] rnd40;
  logic [15:0]          heading_next;
  logic [DW-1:0]        sin_abs;
  logic [TW-1:0]        tan_mag;
  logic                 in_fire;
  logic                 cos_pos;

  assign in_fire = in_valid_i && in_ready_o;
  assign cos_pos = (cor_cos > 0);

  bmpu_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bmpu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  bmpu_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  // Clamp steering to +-70 degrees and take its magnitude
  always_comb begin
    steer_clamped = in_steer_angle_i;
    if (in_steer_angle_i > STEER_POS) begin
      steer_clamped = STEER_POS;
    end else if (in_steer_angle_i < -STEER_POS) begin
      steer_clamped = -STEER_POS;
    end
    steer_mag = steer_clamped[14] ? 14'(-steer_clamped) : steer_clamped[13:0];
  end

  // Rounded views of the last product
  always_comb begin
    rnd16        = bmpu_pkg::round_shr(prod, 16);
    rnd38        = bmpu_pkg::round_shr(prod, 38);
    rnd40        = bmpu_pkg::round_shr(prod, 40);
    heading_next = heading_q + rnd40[15:0];
    sin_abs      = cor_sin[DW-1] ? DW'(-cor_sin) : DW'(cor_sin);
    tan_mag      = div_quot[TW-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmpu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == bmpu_pkg::KIND_LOAD) ? bmpu_pkg::ST_OUT
                                                        : bmpu_pkg::ST_IDX_GO;
        end
      end
      bmpu_pkg::ST_IDX_GO:    state_d = bmpu_pkg::ST_IDX_WAIT;
      bmpu_pkg::ST_IDX_WAIT:  state_d = bmpu_pkg::ST_ANG_GO;
      bmpu_pkg::ST_ANG_GO:    state_d = bmpu_pkg::ST_ANG_WAIT;
      bmpu_pkg::ST_ANG_WAIT:  state_d = bmpu_pkg::ST_TANC_GO;
      bmpu_pkg::ST_TANC_GO:   state_d = bmpu_pkg::ST_TANC_WAIT;
      bmpu_pkg::ST_TANC_WAIT: if (cor_done) state_d = bmpu_pkg::ST_TAND_GO;
      bmpu_pkg::ST_TAND_GO: begin
        state_d = cos_pos ? bmpu_pkg::ST_TAND_WAIT : bmpu_pkg::ST_P_MUL;
      end
      bmpu_pkg::ST_TAND_WAIT: if (div_done) state_d = bmpu_pkg::ST_P_MUL;
      bmpu_pkg::ST_P_MUL:     state_d = bmpu_pkg::ST_R_MUL;
      bmpu_pkg::ST_R_MUL:     state_d = bmpu_pkg::ST_T_MUL;
      bmpu_pkg::ST_T_MUL:     state_d = bmpu_pkg::ST_D_MUL;
      bmpu_pkg::ST_D_MUL:     state_d = bmpu_pkg::ST_HEAD_GO;
      bmpu_pkg::ST_HEAD_GO:   state_d = bmpu_pkg::ST_HEAD_WAIT;
      bmpu_pkg::ST_HEAD_WAIT: if (cor_done) state_d = bmpu_pkg::ST_X_MUL;
      bmpu_pkg::ST_X_MUL:     state_d = bmpu_pkg::ST_Y_MUL;
      bmpu_pkg::ST_Y_MUL:     state_d = bmpu_pkg::ST_Y_SUM;
      bmpu_pkg::ST_Y_SUM:     state_d = bmpu_pkg::ST_OUT;
      bmpu_pkg::ST_OUT:       if (out_ready_i) state_d = bmpu_pkg::ST_IDLE;
      default:                state_d = bmpu_pkg::ST_IDLE;
    endcase
  end

  // Unit controls and handshake outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    cor_start   = 1'b0;
    cor_angle   = ang_q;
    mul_a       = '0;
    mul_b       = '0;
    case (state_q)
      bmpu_pkg::ST_IDLE: in_ready_o = 1'b1;
      bmpu_pkg::ST_IDX_GO: begin
        // nearest table index: (mag*DEPTH + LIMIT/2) / LIMIT by reciprocal
        mul_a = DW'(mag_q) * DW'(bmpu_pkg::TAN_TABLE_DEPTH)
              + DW'(bmpu_pkg::STEER_LIMIT / 2);
        mul_b = DW'(bmpu_pkg::TAN_IDX_RECIP);
      end
      bmpu_pkg::ST_ANG_GO: begin
        // table angle: idx*LIMIT*65536 / DEPTH, as a 32-bit binary angle
        mul_a = DW'(idx_q);
        mul_b = DW'(bmpu_pkg::TAN_ANG_STEP);
      end
      bmpu_pkg::ST_TANC_GO: begin
        cor_start = 1'b1;
        cor_angle = ang_q;
      end
      bmpu_pkg::ST_TAND_GO: begin
        div_start = cos_pos;
        div_num   = {sin_abs[DW-1:0], 16'h0000};
        div_den   = DNW'(cor_cos);
      end
      bmpu_pkg::ST_P_MUL: begin
        mul_a = DW'(speed_q);
        mul_b = $signed({{(DW-16){1'b0}}, ts_q});
      end
      bmpu_pkg::ST_R_MUL: begin
        mul_a = DW'($signed(prod[31:0]));
        mul_b = $signed({{(DW-16){1'b0}}, iwb_q});
      end
      bmpu_pkg::ST_T_MUL: begin
        mul_a = rnd16;
        mul_b = DW'(tn_q);
      end
      bmpu_pkg::ST_D_MUL: begin
        mul_a = rnd16;
        mul_b = bmpu_pkg::RAD_TO_BAM;
      end
      bmpu_pkg::ST_HEAD_GO: begin
        cor_start = 1'b1;
        cor_angle = {heading_next, 16'h0000};
      end
      bmpu_pkg::ST_X_MUL: begin
        mul_a = DW'(p_q);
        mul_b = cor_cos;
      end
      bmpu_pkg::ST_Y_MUL: begin
        mul_a = DW'(p_q);
        mul_b = cor_sin;
      end
      bmpu_pkg::ST_OUT: out_valid_o = 1'b1;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmpu_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q  <= bmpu_pkg::TIME_STEP_RST;
      iwb_q <= bmpu_pkg::INV_WHEEL_BASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bmpu_pkg::REG_TIME_STEP:      ts_q  <= cfg_wdata_i;
        bmpu_pkg::REG_INV_WHEEL_BASE: iwb_q <= cfg_wdata_i;
        default:                      ts_q  <= ts_q;
      endcase
    end
  end

  // Pose state: load replaces it, a step turns then moves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      heading_q <= '0;
    end else begin
      case (state_q)
        bmpu_pkg::ST_IDLE: begin
          if (in_valid_i && (in_kind_i == bmpu_pkg::KIND_LOAD)) begin
            x_q       <= in_new_x_i;
            y_q       <= in_new_y_i;
            heading_q <= in_new_heading_i;
          end
        end
        bmpu_pkg::ST_HEAD_GO: heading_q <= heading_next;
        bmpu_pkg::ST_Y_MUL:   x_q <= bmpu_pkg::sat32(DW'(x_q) + rnd38);
        bmpu_pkg::ST_Y_SUM:   y_q <= bmpu_pkg::sat32(DW'(y_q) + rnd38);
        default:              x_q <= x_q;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      bmpu_pkg::ST_IDLE: begin
        if (in_fire) begin
          speed_q     <= in_speed_i;
          steer_neg_q <= steer_clamped[14];
          mag_q       <= steer_mag;
        end
      end
      bmpu_pkg::ST_IDX_WAIT: idx_q <= prod[bmpu_pkg::TAN_IDX_SHIFT +: IDX_W];
      bmpu_pkg::ST_ANG_WAIT: ang_q <= prod[31:0];
      bmpu_pkg::ST_TAND_GO: begin
        if (!cos_pos) begin
          tn_q <= '0;
        end
      end
      bmpu_pkg::ST_TAND_WAIT: begin
        // tan = sin*65536/cos toward zero, then the steering sign
        if (div_done) begin
          tn_q <= (cor_sin[DW-1] ^ steer_neg_q) ? -$signed(tan_mag) : $signed(tan_mag);
        end
      end
      bmpu_pkg::ST_R_MUL: p_q <= prod[31:0];
      default: begin
        p_q <= p_q;
      end
    endcase
  end

  assign out_pos_x_o   = x_q;
  assign out_pos_y_o   = y_q;
  assign out_heading_o = heading_q;

endmodule

// ===== hw/rtl/bmpu_checker.sv =====
// ----------------------------------------------------------------------------
// bmpu_checker: port-level checks for the pose update block
// Watches the handshakes and the load path; attached by bind.
// ----------------------------------------------------------------------------
module bmpu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               in_kind_i,
  input logic signed [31:0] in_new_x_i,
  input logic signed [31:0] in_new_y_i,
  input logic [15:0]        in_new_heading_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] out_pos_x_o,
  input logic signed [31:0] out_pos_y_o,
  input logic [15:0]        out_heading_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_pos_x_o) && $stable(out_pos_y_o)
       && $stable(out_heading_o)))
    else $error("result changed while stalled");

  // Never take a new transaction while a result waits
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while result pending");

  // After an accept the block is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after accept");

  // A load shows the loaded pose in the next cycle
  a_load_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_kind_i == bmpu_pkg::KIND_LOAD)) |=>
      (out_valid_o && (out_pos_x_o == $past(in_new_x_i))
       && (out_pos_y_o == $past(in_new_y_i))
       && (out_heading_o == $past(in_new_heading_i))))
    else $error("load did not show loaded pose");

endmodule

bind bicycle_model_pose_update bmpu_checker u_bmpu_checker (.*);

// ===== tb/bicycle_model_pose_update_test.sv =====
// ----------------------------------------------------------------------------
// bicycle_model_pose_update_test: self-checking bench for the pose update
// Drives step and load transactions with random gaps and output stalls, keeps
// a bit-exact model of the heading turn, CORDIC motion and saturation, and
// compares every result transaction with the oldest predicted pose.
// ----------------------------------------------------------------------------
module bicycle_model_pose_update_test;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [15:0] heading;
  } pose_t;

  // Pose predictor plus the queue of poses still owed by the block
  class pose_scoreboard;
    logic [15:0] step_len;
    logic [15:0] inv_base;
    logic [31:0] cur_x;
    logic [31:0] cur_y;
    logic [15:0] cur_head;
    longint      tan_lut[bmpu_pkg::TAN_TABLE_DEPTH + 1];
    pose_t       owed[$];
    int          errors;

    function new();
      longint c, s;
      longint unsigned a;
      step_len = bmpu_pkg::TIME_STEP_RST;
      inv_base = bmpu_pkg::INV_WHEEL_BASE_RST;
      cur_x = '0;
      cur_y = '0;
      cur_head = '0;
      errors = 0;
      for (int i = 0; i <= bmpu_pkg::TAN_TABLE_DEPTH; i++) begin
        a = (longint'(i) * bmpu_pkg::STEER_LIMIT * 65536) / bmpu_pkg::TAN_TABLE_DEPTH;
        rotate(a[31:0], c, s);
        tan_lut[i] = (c > 0) ? (s * 65536) / c : 0;
      end
    endfunction

    function longint rnd_shr(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // Rotation-mode CORDIC, half-turn fold for the left half-plane
    function void rotate(logic [31:0] ang, output longint c, output longint s);
      longint z, x, y, xn;
      bit flip;
      z = longint'({32'b0, ang});
      x = bmpu_pkg::CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (z >= (longint'(1) << 31)) z -= longint'(1) << 32;
      if (z > (longint'(1) << 30)) begin
        z -= longint'(1) << 31;
        flip = 1;
      end else if (z < -(longint'(1) << 30)) begin
        z += longint'(1) << 31;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          xn = x - (y >>> i);
          y  = y + (x >>> i);
          z -= longint'(bmpu_pkg::ATAN_ROM[i]);
        end else begin
          xn = x + (y >>> i);
          y  = y - (x >>> i);
          z += longint'(bmpu_pkg::ATAN_ROM[i]);
        end
        x = xn;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function logic [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == bmpu_pkg::REG_TIME_STEP) step_len = val;
      else inv_base = val;
    endfunction

    function void note_item(logic kind, logic signed [15:0] spd, logic signed [14:0] str,
                            logic [31:0] nx, logic [31:0] ny, logic [15:0] nh);
      longint steer, mag, idx, tn, p, r, t, d, c, s, lim, depth;
      lim   = longint'(bmpu_pkg::STEER_LIMIT);
      depth = longint'(bmpu_pkg::TAN_TABLE_DEPTH);
      if (kind == bmpu_pkg::KIND_LOAD) begin
        cur_x = nx;
        cur_y = ny;
        cur_head = nh;
      end else begin
        steer = str;
        if (steer > lim) steer = lim;
        if (steer < -lim) steer = -lim;
        mag = steer < 0 ? -steer : steer;
        idx = (mag * depth + lim / 2) / lim;
        if (idx > depth) idx = depth;
        tn = tan_lut[idx];
        if (steer < 0) tn = -tn;
        p = longint'(spd) * longint'({48'b0, step_len});
        r = rnd_shr(p * longint'({48'b0, inv_base}), 16);
        t = rnd_shr(r * tn, 16);
        d = rnd_shr(t * bmpu_pkg::RAD_TO_BAM, 40);
        cur_head = cur_head + d[15:0];
        rotate({cur_head, 16'b0}, c, s);
        cur_x = sat(longint'(signed'(cur_x)) + rnd_shr(p * c, 38));
        cur_y = sat(longint'(signed'(cur_y)) + rnd_shr(p * s, 38));
      end
      owed.push_back('{cur_x, cur_y, cur_head});
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch: %s got %h want %h", what, got, want);
    endtask

    task check_result(logic [31:0] px, logic [31:0] py, logic [15:0] hd);
      pose_t want;
      if (owed.size() == 0) begin
        report("unexpected result", px, 0);
        return;
      end
      want = owed.pop_front();
      if (px !== want.pos_x) report("pos_x", px, want.pos_x);
      if (py !== want.pos_y) report("pos_y", py, want.pos_y);
      if (hd !== want.heading) report("heading", hd, want.heading);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_index_i;
  logic [15:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               in_kind_i;
  logic signed [15:0] in_speed_i;
  logic signed [14:0] in_steer_angle_i;
  logic signed [31:0] in_new_x_i;
  logic signed [31:0] in_new_y_i;
  logic [15:0]        in_new_heading_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] out_pos_x_o;
  logic signed [31:0] out_pos_y_o;
  logic [15:0]        out_heading_o;

  pose_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;

  bicycle_model_pose_update dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stall the result side at the current phase rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result transaction against the oldest predicted pose
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_pos_x_o, out_pos_y_o, out_heading_o);
    end
  end

  // Present one transaction after a random gap; hold it until accepted
  task send_item(logic kind, logic [15:0] spd, logic [14:0] str,
                 logic [31:0] nx, logic [31:0] ny, logic [15:0] nh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_kind_i        <= kind;
    in_speed_i       <= spd;
    in_steer_angle_i <= str;
    in_new_x_i       <= nx;
    in_new_y_i       <= ny;
    in_new_heading_i <= nh;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(kind, spd, str, nx, ny, nh);
  endtask

  // Drop valid and hold until every owed result is taken
  task drain();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  task write_reg(logic idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task step(logic [15:0] spd, logic [14:0] str);
    send_item(bmpu_pkg::KIND_STEP, spd, str, $urandom, $urandom, 16'($urandom));
  endtask

  task load(logic [31:0] nx, logic [31:0] ny, logic [15:0] nh);
    send_item(bmpu_pkg::KIND_LOAD, 16'($urandom), 15'($urandom), nx, ny, nh);
  endtask

  // Mostly steps with random speed and steering, some pose loads
  task random_items(int n);
    logic [15:0] spd;
    logic [14:0] str;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        load($urandom, $urandom, 16'($urandom));
      end else begin
        case ($urandom_range(2))
          0: spd = 16'($urandom);
          1: spd = 16'($urandom_range(2047) - 1024);
          default: spd = $urandom_range(1) ? 16'h7fff : 16'h8000;
        endcase
        str = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(25486) - 12743);
        step(spd, str);
      end
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = bmpu_pkg::REG_TIME_STEP;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    in_kind_i        = bmpu_pkg::KIND_STEP;
    in_speed_i       = '0;
    in_steer_angle_i = '0;
    in_new_x_i       = '0;
    in_new_y_i       = '0;
    in_new_heading_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, clamp beyond the steering limit, saturation
    step(16'sd256, 15'sd0);
    step(16'sh7fff, 15'sd12743);
    step(16'sh8000, -15'sd12743);
    step(16'sh7fff, 15'sh3fff);
    step(16'sh7fff, 15'sh4000);
    step(16'sd1000, 15'sd100);
    step(16'sd0, 15'sd5000);
    load(32'h7fff0000, 32'h7fff0000, 16'h0000);
    step(16'sh7fff, 15'sd0);
    load(32'h7fffffff, 32'h80000000, 16'h2000);
    step(16'sh7fff, 15'sd0);
    load(32'h80000000, 32'h7fffffff, 16'hc000);
    step(16'sh7fff, 15'sd0);
    step(16'sh8000, 15'sd0);
    load(32'h0, 32'h0, 16'hffff);
    step(16'sh7fff, -15'sd1);
    load(32'h0, 32'h0, 16'h8000);
    step(16'sd500, 15'sd6000);
    drain();

    // Extreme registers: full turns wrap the heading
    write_reg(bmpu_pkg::REG_TIME_STEP, 16'hffff);
    write_reg(bmpu_pkg::REG_INV_WHEEL_BASE, 16'hffff);
    step(16'sh7fff, 15'sd12743);
    step(16'sh8000, 15'sd12743);
    step(16'sh7fff, -15'sd12743);
    random_items(100);
    drain();

    // Hold off until all results are in, then run with a starved sender
    write_reg(bmpu_pkg::REG_TIME_STEP, 16'd1);
    write_reg(bmpu_pkg::REG_INV_WHEEL_BASE, 16'd1);
    send_idle_pct = 82;
    random_items(100);
    drain();

    write_reg(bmpu_pkg::REG_TIME_STEP, 16'($urandom_range(65535, 1)));
    write_reg(bmpu_pkg::REG_INV_WHEEL_BASE, 16'($urandom_range(65535, 1)));
    send_idle_pct  = 0;
    recv_stall_pct = 82;
    random_items(100);
    drain();

    write_reg(bmpu_pkg::REG_TIME_STEP, bmpu_pkg::TIME_STEP_RST);
    write_reg(bmpu_pkg::REG_INV_WHEEL_BASE, bmpu_pkg::INV_WHEEL_BASE_RST);
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    random_items(100);
    drain();

    // Catch any stray result after the last one owed
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bmpu_pkg.sv
hw/rtl/bmpu_mul.sv
hw/rtl/bmpu_div.sv
hw/rtl/bmpu_cordic.sv
hw/rtl/bicycle_model_pose_update.sv
hw/rtl/bmpu_checker.sv
tb/bicycle_model_pose_update_test.sv
